### hdl/lfgr_pkg.sv
`timescale 1ns / 1ps

package lfgr_pkg;

    localparam int DEF_FRAME_COUNT_BITS = 16;

    localparam int SAMPLE_W    = 16;
    localparam int GAIN_REG_W  = 18;
    localparam int FRAME_REG_W = 16;
    localparam int CHAN_REG_W  = 4;
    localparam int CHAN_IDX_W  = 3;
    localparam int GAIN_W      = 16;
    localparam int CFG_W       = 18;
    localparam int CFG_IDX_W   = 2;
    localparam int MAX_CHANNELS = 8;

    // quotient bits resolved per divider step
    localparam int DIV_STEP_BITS = 4;

    localparam logic signed [GAIN_REG_W-1:0] UNITY_GAIN  = 18'sd32768;
    localparam logic signed [GAIN_REG_W-1:0] BYPASS_GAIN = 18'sd32765;
    localparam logic [GAIN_W-1:0]            UNITY_GAIN_U = 16'd32768;
    localparam logic signed [32:0]           ROUND_HALF  = 33'sd16384;

    localparam logic [FRAME_REG_W-1:0] FRAME_COUNT_RST = 16'd1;
    localparam logic [CHAN_REG_W-1:0]  CHAN_COUNT_RST  = 4'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_GAIN    = 2'd0,
        CFG_END_GAIN      = 2'd1,
        CFG_FRAME_COUNT   = 2'd2,
        CFG_CHANNEL_COUNT = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic take;
        logic mul;
        logic div;
        logic sum;
        logic scale;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic chan_zero;
    } t_dp_stat;

endpackage

### hdl/lfgr_ctrl.sv
`timescale 1ns / 1ps

module lfgr_ctrl #(
    parameter int FRAME_COUNT_BITS = lfgr_pkg::DEF_FRAME_COUNT_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  lfgr_pkg::t_dp_stat i_stat,
    output lfgr_pkg::t_dp_cmd  o_cmd
);

    localparam int MW     = lfgr_pkg::GAIN_REG_W + FRAME_COUNT_BITS;
    localparam int SB     = lfgr_pkg::DIV_STEP_BITS;
    localparam int DW     = ((MW + SB - 1) / SB) * SB;
    localparam int NSTEP  = DW / SB;
    localparam int STEP_W = $clog2(NSTEP);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_MUL   = 6'b000010,
        ST_DIV   = 6'b000100,
        ST_SUM   = 6'b001000,
        ST_SCALE = 6'b010000,
        ST_EMIT  = 6'b100000
    } t_state;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_out_valid, n_out_valid;
    logic              w_take;
    logic              w_out_free;

    assign w_take     = i_in_valid && (r_state == ST_IDLE);
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                if (w_take) begin
                    o_cmd.take = 1'b1;
                    n_state    = i_stat.chan_zero ? ST_MUL : ST_SCALE;
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_step    = STEP_W'(NSTEP - 1);
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div = 1'b1;
                if (r_step == '0) begin
                    n_state = ST_SUM;
                end else begin
                    n_step = r_step - 1'b1;
                end
            end
            ST_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = ST_SCALE;
            end
            ST_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = ST_EMIT;
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

### hdl/lfgr_dp.sv
`timescale 1ns / 1ps

module lfgr_dp #(
    parameter int FRAME_COUNT_BITS = lfgr_pkg::DEF_FRAME_COUNT_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [lfgr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [lfgr_pkg::CFG_W-1:0]       i_cfg_wdata,
    input  logic [lfgr_pkg::SAMPLE_W-1:0]    i_sample,
    output logic [lfgr_pkg::SAMPLE_W-1:0]    o_sample,
    output logic                             o_last,
    input  lfgr_pkg::t_dp_cmd                i_cmd,
    output lfgr_pkg::t_dp_stat               o_stat
);

    localparam int FCB  = FRAME_COUNT_BITS;
    localparam int FC_W = (FCB < lfgr_pkg::FRAME_REG_W) ? FCB : lfgr_pkg::FRAME_REG_W;
    localparam int GW   = lfgr_pkg::GAIN_REG_W;
    localparam int MW   = GW + FCB;
    localparam int SB   = lfgr_pkg::DIV_STEP_BITS;
    localparam int DW   = ((MW + SB - 1) / SB) * SB;
    localparam int SW   = lfgr_pkg::SAMPLE_W;
    localparam int CW   = lfgr_pkg::CHAN_IDX_W;
    localparam int CRW  = lfgr_pkg::CHAN_REG_W;

    // configuration
    logic signed [GW-1:0]  r_start_gain;
    logic signed [GW-1:0]  r_end_gain;
    logic [FC_W-1:0]       r_frame_count;
    logic [CRW-1:0]        r_chan_count;

    // counters and gain
    logic [FCB-1:0]        r_frame_idx;
    logic [CW-1:0]         r_chan_idx;
    logic [lfgr_pkg::GAIN_W-1:0] r_gain;

    // working registers
    logic signed [SW-1:0]  r_sample;
    logic                  r_neg;
    logic [DW-1:0]         r_div;
    logic [FC_W-1:0]       r_rem;
    logic signed [32:0]    r_prod;
    logic [SW-1:0]         r_out_data;
    logic                  r_out_last;

    logic [FC_W-1:0]       w_eff_frames;
    logic [CRW-1:0]        w_eff_chan;
    logic signed [GW:0]    w_diff;
    logic signed [FCB+GW+1:0] w_gprod;
    logic signed [FCB+GW+1:0] w_gmag;
    logic [DW-1:0]         w_quo;
    logic [FC_W-1:0]       w_rem;
    logic signed [DW:0]    w_qs;
    logic [DW+1:0]         w_sum;
    logic [lfgr_pkg::GAIN_W-1:0] w_gain;
    logic signed [32:0]    w_sprod;
    logic                  w_bypass;
    logic                  w_last_chan;
    logic                  w_last_frame;

    assign w_eff_frames = (r_frame_count == '0) ? FC_W'(1) : r_frame_count;

    always_comb begin
        if (r_chan_count == '0) begin
            w_eff_chan = CRW'(1);
        end else if (r_chan_count > CRW'(lfgr_pkg::MAX_CHANNELS)) begin
            w_eff_chan = CRW'(lfgr_pkg::MAX_CHANNELS);
        end else begin
            w_eff_chan = r_chan_count;
        end
    end

    // ramp offset product
    assign w_diff  = {r_end_gain[GW-1], r_end_gain} - {r_start_gain[GW-1], r_start_gain};
    assign w_gprod = w_diff * $signed({1'b0, r_frame_idx});
    assign w_gmag  = w_gprod[FCB+GW+1] ? -w_gprod : w_gprod;

    // restoring divider, several quotient bits per step
    always_comb begin
        logic [FC_W:0] v_part;
        v_part = '0;
        w_rem  = r_rem;
        w_quo  = r_div;
        for (int k = 0; k < SB; k++) begin
            v_part = {w_rem, w_quo[DW-1]};
            w_quo  = {w_quo[DW-2:0], 1'b0};
            if (v_part >= {1'b0, w_eff_frames}) begin
                v_part   = v_part - {1'b0, w_eff_frames};
                w_quo[0] = 1'b1;
            end
            w_rem = v_part[FC_W-1:0];
        end
    end

    // gain = start + signed quotient, clamped to [0, unity]
    assign w_qs  = r_neg ? -$signed({1'b0, r_div}) : $signed({1'b0, r_div});
    assign w_sum = {w_qs[DW], w_qs} + {{(DW + 2 - GW){r_start_gain[GW-1]}}, r_start_gain};

    always_comb begin
        if (w_sum[DW+1]) begin
            w_gain = '0;
        end else if (w_sum > (DW + 2)'(lfgr_pkg::UNITY_GAIN_U)) begin
            w_gain = lfgr_pkg::UNITY_GAIN_U;
        end else begin
            w_gain = w_sum[lfgr_pkg::GAIN_W-1:0];
        end
    end

    assign w_sprod  = r_sample * $signed({1'b0, r_gain});
    assign w_bypass = (r_start_gain >= lfgr_pkg::BYPASS_GAIN)
                   && (r_end_gain >= lfgr_pkg::BYPASS_GAIN);

    assign w_last_chan  = ({1'b0, r_chan_idx} + CRW'(1)) >= w_eff_chan;
    assign w_last_frame = ({1'b0, r_frame_idx} + (FCB + 1)'(1)) >= (FCB + 1)'(w_eff_frames);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_gain  <= lfgr_pkg::UNITY_GAIN;
            r_end_gain    <= lfgr_pkg::UNITY_GAIN;
            r_frame_count <= FC_W'(lfgr_pkg::FRAME_COUNT_RST);
            r_chan_count  <= lfgr_pkg::CHAN_COUNT_RST;
            r_frame_idx   <= '0;
            r_chan_idx    <= '0;
            r_gain        <= lfgr_pkg::UNITY_GAIN_U;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    lfgr_pkg::CFG_START_GAIN:    r_start_gain  <= $signed(i_cfg_wdata);
                    lfgr_pkg::CFG_END_GAIN:      r_end_gain    <= $signed(i_cfg_wdata);
                    lfgr_pkg::CFG_FRAME_COUNT:   r_frame_count <= i_cfg_wdata[FC_W-1:0];
                    lfgr_pkg::CFG_CHANNEL_COUNT: r_chan_count  <= i_cfg_wdata[CRW-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.sum) begin
                r_gain <= w_gain;
            end
            if (i_cmd.emit) begin
                if (w_last_chan) begin
                    r_chan_idx  <= '0;
                    r_frame_idx <= w_last_frame ? '0 : r_frame_idx + 1'b1;
                end else begin
                    r_chan_idx <= r_chan_idx + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_sample <= $signed(i_sample);
        end
        if (i_cmd.mul) begin
            r_neg <= w_gprod[FCB+GW+1];
            r_div <= DW'(w_gmag[MW-1:0]);
            r_rem <= '0;
        end
        if (i_cmd.div) begin
            r_div <= w_quo;
            r_rem <= w_rem;
        end
        if (i_cmd.scale) begin
            r_prod <= w_sprod + lfgr_pkg::ROUND_HALF;
        end
        if (i_cmd.emit) begin
            r_out_data <= w_bypass ? r_sample : r_prod[30:15];
            r_out_last <= w_last_chan && w_last_frame;
        end
    end

    assign o_stat.chan_zero = (r_chan_idx == '0);
    assign o_sample         = r_out_data;
    assign o_last           = r_out_last;

endmodule

### hdl/linear_fade_gain_ramp.sv
`timescale 1ns / 1ps

// Linear gain fade over interleaved Q1.15 audio.
// s_axis carries one sample per transaction (tdata[15:0] = sample_in).
// m_axis returns one faded sample per input (tdata[15:0] = sample_out),
// with tlast set on the last channel sample of the final frame of a fade.
// The config port writes start_gain, end_gain, frame_count and
// channel_count by index 0 to 3; write only while the block is idle.
// At the first channel of each frame the gain is recomputed: a multiply
// step, then a restoring divider that resolves 4 quotient bits a cycle,
// then an add and clamp step. Every sample then goes through a multiply
// and an output load. A sample is taken only while idle, so no new
// sample is taken until the last one has been loaded into the output.
// A stalled m_axis holds its output register; one more sample is taken
// and worked on, then the block waits until the output is free.
// Reset clears the counters and loads the reset register values.

module linear_fade_gain_ramp #(
    parameter int FRAME_COUNT_BITS = lfgr_pkg::DEF_FRAME_COUNT_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [lfgr_pkg::SAMPLE_W-1:0]  s_axis_tdata,   // [15:0] sample_in
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [lfgr_pkg::SAMPLE_W-1:0]  m_axis_tdata,   // [15:0] sample_out
    output logic                           m_axis_tlast,
    input  logic                           i_cfg_wr_en,
    input  logic [lfgr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lfgr_pkg::CFG_W-1:0]     i_cfg_wdata
);

    lfgr_pkg::t_dp_cmd  w_cmd;
    lfgr_pkg::t_dp_stat w_stat;

    lfgr_ctrl #(
        .FRAME_COUNT_BITS (FRAME_COUNT_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    lfgr_dp #(
        .FRAME_COUNT_BITS (FRAME_COUNT_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_sample    (s_axis_tdata),
        .o_sample    (m_axis_tdata),
        .o_last      (m_axis_tlast),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat)
    );

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 20;

    typedef struct {
        logic [lfgr_pkg::SAMPLE_W-1:0] sample;
        logic                          last;
    } t_faded_sample;

    class fade_scoreboard;
        logic signed [lfgr_pkg::GAIN_REG_W-1:0] start_gain;
        logic signed [lfgr_pkg::GAIN_REG_W-1:0] end_gain;
        logic [lfgr_pkg::FRAME_REG_W-1:0]       frame_count;
        logic [lfgr_pkg::CHAN_REG_W-1:0]        chan_count;
        logic [lfgr_pkg::FRAME_REG_W-1:0]       frame_idx;
        logic [lfgr_pkg::CHAN_IDX_W-1:0]        chan_idx;
        logic [lfgr_pkg::GAIN_W-1:0]            frame_gain;
        t_faded_sample                          faded_q[$];
        int                                     errors;

        function new();
            start_gain  = lfgr_pkg::UNITY_GAIN;
            end_gain    = lfgr_pkg::UNITY_GAIN;
            frame_count = lfgr_pkg::FRAME_COUNT_RST;
            chan_count  = lfgr_pkg::CHAN_COUNT_RST;
            frame_idx   = '0;
            chan_idx    = '0;
            frame_gain  = lfgr_pkg::UNITY_GAIN_U;
            errors      = 0;
        endfunction

        function void write_reg(lfgr_pkg::t_cfg_idx idx, logic [lfgr_pkg::CFG_W-1:0] v);
            case (idx)
                lfgr_pkg::CFG_START_GAIN: begin
                    start_gain = v;
                end
                lfgr_pkg::CFG_END_GAIN: begin
                    end_gain = v;
                end
                lfgr_pkg::CFG_FRAME_COUNT: begin
                    frame_count = v[lfgr_pkg::FRAME_REG_W-1:0];
                end
                lfgr_pkg::CFG_CHANNEL_COUNT: begin
                    chan_count = v[lfgr_pkg::CHAN_REG_W-1:0];
                end
                default: begin
                end
            endcase
        endfunction

        // works out the faded sample for one accepted transaction
        function void take_sample(logic [lfgr_pkg::SAMPLE_W-1:0] s);
            t_faded_sample res;
            longint diff;
            longint g;
            longint p;
            int frames;
            int chans;
            logic last_chan;
            logic last_frame;

            frames = (frame_count == 0) ? 1 : int'(frame_count);
            if (chan_count == 0) begin
                chans = 1;
            end else if (chan_count > lfgr_pkg::MAX_CHANNELS) begin
                chans = lfgr_pkg::MAX_CHANNELS;
            end else begin
                chans = int'(chan_count);
            end

            if (chan_idx == 0) begin
                diff = longint'(end_gain) - longint'(start_gain);
                g = longint'(start_gain) + (diff * longint'(frame_idx)) / longint'(frames);
                if (g < 0) begin
                    frame_gain = '0;
                end else if (g > longint'(lfgr_pkg::UNITY_GAIN_U)) begin
                    frame_gain = lfgr_pkg::UNITY_GAIN_U;
                end else begin
                    frame_gain = g[lfgr_pkg::GAIN_W-1:0];
                end
            end

            if (start_gain >= lfgr_pkg::BYPASS_GAIN && end_gain >= lfgr_pkg::BYPASS_GAIN) begin
                res.sample = s;
            end else begin
                p = longint'($signed(s)) * longint'(frame_gain) + 64'sd16384;
                p = p >>> 15;
                res.sample = p[lfgr_pkg::SAMPLE_W-1:0];
            end

            last_chan  = (int'(chan_idx) + 1 >= chans);
            last_frame = (int'(frame_idx) + 1 >= frames);
            res.last   = last_chan && last_frame;

            if (last_chan) begin
                chan_idx = '0;
                frame_idx = last_frame ? '0 : frame_idx + 1'b1;
            end else begin
                chan_idx = chan_idx + 1'b1;
            end
            faded_q.push_back(res);
        endfunction

        task report(string msg);
            errors++;
            $display("mismatch: %s", msg);
        endtask

        task check_faded(logic [lfgr_pkg::SAMPLE_W-1:0] data, logic last);
            t_faded_sample want;
            if (faded_q.size() == 0) begin
                report($sformatf("output %h tlast %b with nothing pending", data, last));
                return;
            end
            want = faded_q.pop_front();
            if (data !== want.sample) begin
                report($sformatf("sample_out %h, wanted %h", data, want.sample));
            end
            if (last !== want.last) begin
                report($sformatf("tlast %b, wanted %b", last, want.last));
            end
        endtask
    endclass

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [lfgr_pkg::SAMPLE_W-1:0]  s_axis_tdata = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [lfgr_pkg::SAMPLE_W-1:0]  m_axis_tdata;
    logic                           m_axis_tlast;
    logic                           i_cfg_wr_en = 1'b0;
    logic [lfgr_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [lfgr_pkg::CFG_W-1:0]     i_cfg_wdata = '0;

    fade_scoreboard fade;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    logic hold_trigger = 1'b0;
    logic rx_hold = 1'b0;
    int  cycle_count = 0;

    linear_fade_gain_ramp dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("linear_fade_gain_ramp test failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (rx_hold) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // long output back-pressure so the block fills up
    initial begin
        wait (hold_trigger);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            fade.take_sample(s_axis_tdata);
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            fade.check_faded(m_axis_tdata, m_axis_tlast);
        end
    end

    task automatic send_sample(input logic [lfgr_pkg::SAMPLE_W-1:0] v);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (fade.faded_q.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input lfgr_pkg::t_cfg_idx idx,
                             input logic [lfgr_pkg::CFG_W-1:0] v);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        fade.write_reg(idx, v);
    endtask

    // unused upper data bits get junk on the narrow registers
    task automatic load_fade(input int sg, input int eg, input int fc, input int cc);
        write_reg(lfgr_pkg::CFG_START_GAIN, lfgr_pkg::CFG_W'(sg));
        write_reg(lfgr_pkg::CFG_END_GAIN, lfgr_pkg::CFG_W'(eg));
        write_reg(lfgr_pkg::CFG_FRAME_COUNT, {2'($urandom()), 16'(fc)});
        write_reg(lfgr_pkg::CFG_CHANNEL_COUNT, {14'($urandom()), 4'(cc)});
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic int pick_gain();
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 1) ? 131071 : -131072;
            1: return -65536;
            2: return 65536;
            3: return 32768;
            4: return 32765;
            5: return 32764;
            6: return 0;
            7: return int'($urandom_range(0, 262143)) - 131072;
            default: return $urandom_range(0, 32768);
        endcase
    endfunction

    function automatic logic [lfgr_pkg::SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 15))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'hffff;
            3: return 16'h0001;
            default: return lfgr_pkg::SAMPLE_W'($urandom());
        endcase
    endfunction

    initial begin
        int n_items;
        int fc;
        int cc;

        fade = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 23;
        recv_idle_pct = 67;

        // reset settings: unity both ends, pass-through
        send_sample(16'h8000);
        send_sample(16'h7fff);
        send_sample(16'h0000);
        send_sample(16'hffff);
        drain();

        // ramp from silence, rounding ties
        load_fade(0, 32768, 2, 2);
        send_sample(16'h8000);
        send_sample(16'h0001);
        send_sample(16'h7fff);
        send_sample(16'hffff);
        drain();

        // falling ramp clamped at both ends
        load_fade(65536, -65536, 3, 1);
        send_sample(16'h7fff);
        send_sample(16'h8000);
        send_sample(16'h7fff);
        drain();

        // zero frame and channel counts
        load_fade(16384, 0, 0, 0);
        send_sample(16'h8000);
        send_sample(16'h7fff);
        drain();

        // bypass threshold, channel count above eight
        load_fade(32765, 32765, 1, 15);
        repeat (8) send_sample(pick_sample());
        drain();

        // just below bypass
        load_fade(32764, 65536, 2, 3);
        send_sample(16'h7fff);
        send_sample(16'h8000);
        send_sample(16'h5555);
        drain();

        for (int ph = 0; ph < 12; ph++) begin
            if (ph < 4) begin
                send_idle_pct = 23;
                recv_idle_pct = 67;
            end else if (ph < 8) begin
                send_idle_pct = 67;
                recv_idle_pct = 23;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (ph == 8) begin
                hold_trigger <= 1'b1;
            end

            case ($urandom_range(0, 9))
                0: fc = 0;
                1: fc = 65535;
                2: fc = $urandom_range(0, 65535);
                default: fc = $urandom_range(1, 8);
            endcase
            cc = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
            load_fade(pick_gain(), pick_gain(), fc, cc);

            n_items = $urandom_range(60, 100);
            repeat (n_items) send_sample(pick_sample());
            drain();
        end

        if (fade.faded_q.size() != 0) begin
            fade.report($sformatf("%0d outputs never arrived", fade.faded_q.size()));
        end
        if (fade.errors == 0) begin
            $display("linear_fade_gain_ramp test passed");
        end else begin
            $display("linear_fade_gain_ramp test failed");
        end
        $finish;
    end

endmodule
